FILE: rtl/core/abf_pkg.sv
// Shared types and constants of the aligned best-fit range allocator.
`default_nettype none
package abf_pkg;

  // Width of the alignment field of an input item.
  localparam int ALIGN_W = 17;

  // Region size after reset.
  localparam int RESET_SIZE = 65536;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FIXED = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DIV,
    S_ADV,
    S_DECIDE,
    S_MV_CHK,
    S_MV_WR,
    S_PUT1,
    S_PUT2,
    S_SUM_INIT,
    S_SUM_CHK,
    S_SUM_EV,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/abf_ifs.sv
// Handshake interfaces for the request, result and configuration channels.
`default_nettype none
interface abf_in_if import abf_pkg::*; #(parameter int ADDR_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [ADDR_BITS-1:0] address;
  logic [ADDR_BITS-1:0] length;
  logic [ALIGN_W-1:0]   alignment;
  logic                 direction;
  modport source (output valid, command, address, length, alignment, direction, input ready);
  modport sink (input valid, command, address, length, alignment, direction, output ready);
endinterface

interface abf_out_if #(parameter int ADDR_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] result_address;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] total_free;
  logic [ADDR_BITS-1:0] largest_free;
  modport source (output valid, result_address, status, total_free, largest_free,
                  input ready);
  modport sink (input valid, result_address, status, total_free, largest_free,
                output ready);
endinterface

interface abf_cfg_if #(parameter int ADDR_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] total_size;
  modport source (output valid, total_size, input ready);
  modport sink (input valid, total_size, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/aligned_best_fit_gap_allocator.sv
// Top level of the aligned best-fit range allocator.
//
// The block keeps a sorted table of free ranges {start, end} of the region
// [0, total_size) in a single-port-write, registered-read memory, and serves
// one item at a time: best-fit allocate, fixed allocate or free. After reset
// the init state writes the initial full-region range; a configuration
// write of total_size resets the table the same way and is taken only while
// idle. For every range that is a candidate of a best-fit allocate, the
// aligned start is found by a bit-serial remainder unit shared by all
// ranges. Inserts and removals of table entries then move the table tail,
// and a final pass totals the free bytes and the largest free range.
// Results go to an output register, so a new item is taken while the last
// result still waits.
`default_nettype none
module aligned_best_fit_gap_allocator import abf_pkg::*; #(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  abf_in_if.sink   in_ch,
  abf_out_if.source out_ch,
  abf_cfg_if.sink  cfg_ch
);
  localparam int AB = ADDR_BITS;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int AW = $clog2(MAX_RANGES);
  localparam int XW = ((AB > ALIGN_W) ? AB : ALIGN_W) + 1;
  localparam int DW = 2 * AB;
  localparam logic [AB-1:0] TOT_RST = AB'(RESET_SIZE);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);

  // Control state.
  state_t        state_r, state_nxt;
  logic [AB-1:0] tot_r, tot_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;

  // Latched item and working registers.
  cmd_t               cmd_r, cmd_nxt;
  logic [AB-1:0]      addr_r, addr_nxt;
  logic [AB-1:0]      len_r, len_nxt;
  logic [ALIGN_W-1:0] al_r, al_nxt;
  logic               dir_r, dir_nxt;
  logic [AB:0]        end_r, end_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               fb_r, fb_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      best_r, best_nxt;
  logic [AB-1:0]      bsz_r, bsz_nxt;
  logic [AB-1:0]      bst_r, bst_nxt;
  logic [AB-1:0]      ben_r, ben_nxt;
  logic [AB-1:0]      ba_r, ba_nxt;
  logic [AB-1:0]      cs_r, cs_nxt;
  logic [AB-1:0]      ce_r, ce_nxt;
  logic [XW-1:0]      x_r, x_nxt;
  logic               ovl_r, ovl_nxt;
  logic               pfound_r, pfound_nxt;
  logic               prv_v_r, prv_v_nxt;
  logic [AB-1:0]      prv_s_r, prv_s_nxt;
  logic [AB-1:0]      prv_e_r, prv_e_nxt;
  status_t            st_r, st_nxt;
  logic [AB-1:0]      res_r, res_nxt;
  logic               w1v_r, w1v_nxt;
  logic [CW-1:0]      w1a_r, w1a_nxt;
  logic [DW-1:0]      w1d_r, w1d_nxt;
  logic               w2v_r, w2v_nxt;
  logic [CW-1:0]      w2a_r, w2a_nxt;
  logic [DW-1:0]      w2d_r, w2d_nxt;
  logic               mv_on_r, mv_on_nxt;
  logic               asc_r, asc_nxt;
  logic [CW-1:0]      lim_r, lim_nxt;
  logic               inc_r, inc_nxt;
  logic               dec_r, dec_nxt;
  logic [AB-1:0]      sum_r, sum_nxt;
  logic [AB-1:0]      big_r, big_nxt;

  // Output register.
  logic [AB-1:0] o_res_r, o_tot_r, o_big_r;
  logic [1:0]    o_st_r;

  // Memory ports.
  logic          mem_we;
  logic [CW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  logic [CW-1:0] mem_ra;
  logic [DW-1:0] mem_rq;

  // Remainder unit.
  logic               div_start;
  logic               div_done;
  logic [ALIGN_W-1:0] div_rem;

  // Decision plan, built from the scan results.
  status_t       pl_st;
  logic [AB-1:0] pl_res;
  logic          pl_w1v, pl_w2v, pl_mv, pl_asc, pl_inc, pl_dec;
  logic [CW-1:0] pl_w1a, pl_w2a, pl_from, pl_lim;
  logic [DW-1:0] pl_w1d, pl_w2d;

  logic          in_hs, cfg_hs, load_out;
  logic [AB-1:0] q_s, q_e, q_sz;
  logic          q_need, q_in_fix, q_ovl;
  logic [AB:0]   end_w;
  logic          chk_bad;
  status_t       chk_st;
  logic [XW-1:0] x_w, a_x;
  logic          fit_ok;
  logic          prim_end, scan_end, mv_more;
  logic [AB-1:0] a_len, end_a;
  logic          full;

  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_hs       = cfg_ch.valid && cfg_ch.ready;
  assign in_hs        = in_ch.valid && in_ch.ready;
  assign load_out     = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  assign q_s  = mem_rq[DW-1:AB];
  assign q_e  = mem_rq[AB-1:0];
  assign q_sz = q_e - q_s;

  // A range is only sent to the remainder unit if it could replace the best.
  assign q_need   = (q_sz >= len_r) && (!found_r || (q_sz < bsz_r));
  assign q_in_fix = ({1'b0, q_s} <= {1'b0, addr_r}) && ({1'b0, q_e} >= end_r);
  assign q_ovl    = ({1'b0, q_s} < end_r) && (addr_r < q_e);

  assign end_w = {1'b0, addr_r} + {1'b0, len_r};

  // Upward rounds start + alignment - 1 down, downward rounds end - length.
  assign x_w = dir_r ? XW'(q_e - len_r)
                     : XW'(q_s) + XW'(al_r) - XW'(1);
  assign a_x = x_r - XW'(div_rem);
  assign fit_ok = dir_r ? (a_x >= XW'(cs_r))
                        : (({1'b0, a_x} + (XW + 1)'(len_r)) <= (XW + 1)'(ce_r));

  // Upward the main scan ends at the next to last range, downward at entry 1.
  assign prim_end = dir_r ? (idx_r == CW'(1)) : ((idx_r + CW'(2)) == cnt_r);
  assign scan_end = (idx_r + CW'(1)) == cnt_r;
  assign mv_more  = mv_on_r && (asc_r ? ((idx_r + CW'(1)) < cnt_r) : (idx_r > lim_r));

  assign a_len = ba_r + len_r;
  assign end_a = end_r[AB-1:0];
  assign full  = (cnt_r >= CNT_MAX);

  always_comb begin
    chk_bad = 1'b0;
    chk_st  = ST_OK;
    if ((len_r == '0) || (cmd_r == CMD_BAD)) begin
      chk_bad = 1'b1;
      chk_st  = ST_INVALID;
    end else if (cmd_r == CMD_ALLOC) begin
      if (al_r == '0) begin
        chk_bad = 1'b1;
        chk_st  = ST_INVALID;
      end else if (cnt_r == '0) begin
        chk_bad = 1'b1;
        chk_st  = ST_NOFIT;
      end
    end else if (end_w > {1'b0, tot_r}) begin
      chk_bad = 1'b1;
      chk_st  = ST_INVALID;
    end
  end

  // Turns the scan result into table writes, a tail move and a count change.
  // A split keeps the lower piece at the found entry and inserts the upper
  // piece right after it.
  always_comb begin
    pl_st   = ST_OK;
    pl_res  = '0;
    pl_w1v  = 1'b0;
    pl_w1a  = '0;
    pl_w1d  = '0;
    pl_w2v  = 1'b0;
    pl_w2a  = '0;
    pl_w2d  = '0;
    pl_mv   = 1'b0;
    pl_asc  = 1'b1;
    pl_from = '0;
    pl_lim  = '0;
    pl_inc  = 1'b0;
    pl_dec  = 1'b0;
    unique case (cmd_r)
      CMD_ALLOC: begin
        if (!found_r) begin
          pl_st = ST_NOFIT;
        end else if ((ba_r == bst_r) && (a_len == ben_r)) begin
          pl_res  = ba_r;
          pl_mv   = 1'b1;
          pl_from = best_r;
          pl_dec  = 1'b1;
        end else if (a_len == ben_r) begin
          pl_res = ba_r;
          pl_w1v = 1'b1;
          pl_w1a = best_r;
          pl_w1d = {bst_r, ba_r};
        end else if (ba_r == bst_r) begin
          pl_res = ba_r;
          pl_w1v = 1'b1;
          pl_w1a = best_r;
          pl_w1d = {a_len, ben_r};
        end else if (full) begin
          pl_st = ST_FULL;
        end else begin
          pl_res  = ba_r;
          pl_mv   = 1'b1;
          pl_asc  = 1'b0;
          pl_from = cnt_r;
          pl_lim  = best_r + CW'(1);
          pl_inc  = 1'b1;
          pl_w1v  = 1'b1;
          pl_w1a  = best_r + CW'(1);
          pl_w1d  = {a_len, ben_r};
          pl_w2v  = 1'b1;
          pl_w2a  = best_r;
          pl_w2d  = {bst_r, ba_r};
        end
      end
      CMD_FIXED: begin
        if (!found_r) begin
          pl_st = ST_INVALID;
        end else if ((bst_r == addr_r) && (ben_r == end_a)) begin
          pl_res  = addr_r;
          pl_mv   = 1'b1;
          pl_from = best_r;
          pl_dec  = 1'b1;
        end else if (bst_r == addr_r) begin
          pl_res = addr_r;
          pl_w1v = 1'b1;
          pl_w1a = best_r;
          pl_w1d = {end_a, ben_r};
        end else if (ben_r == end_a) begin
          pl_res = addr_r;
          pl_w1v = 1'b1;
          pl_w1a = best_r;
          pl_w1d = {bst_r, addr_r};
        end else if (full) begin
          pl_st = ST_FULL;
        end else begin
          pl_res  = addr_r;
          pl_mv   = 1'b1;
          pl_asc  = 1'b0;
          pl_from = cnt_r;
          pl_lim  = best_r + CW'(1);
          pl_inc  = 1'b1;
          pl_w1v  = 1'b1;
          pl_w1a  = best_r + CW'(1);
          pl_w1d  = {end_a, ben_r};
          pl_w2v  = 1'b1;
          pl_w2a  = best_r;
          pl_w2d  = {bst_r, addr_r};
        end
      end
      CMD_FREE: begin
        // The following range is held in best/bst/ben, the preceding in prv.
        if (ovl_r) begin
          pl_st = ST_INVALID;
        end else if (prv_v_r && (prv_e_r == addr_r) && pfound_r && (bst_r == end_a)) begin
          pl_w1v  = 1'b1;
          pl_w1a  = best_r - CW'(1);
          pl_w1d  = {prv_s_r, ben_r};
          pl_mv   = 1'b1;
          pl_from = best_r;
          pl_dec  = 1'b1;
        end else if (prv_v_r && (prv_e_r == addr_r)) begin
          pl_w1v = 1'b1;
          pl_w1a = (pfound_r ? best_r : cnt_r) - CW'(1);
          pl_w1d = {prv_s_r, end_a};
        end else if (pfound_r && (bst_r == end_a)) begin
          pl_w1v = 1'b1;
          pl_w1a = best_r;
          pl_w1d = {addr_r, ben_r};
        end else if (full) begin
          pl_st = ST_FULL;
        end else begin
          pl_mv   = 1'b1;
          pl_asc  = 1'b0;
          pl_from = cnt_r;
          pl_lim  = pfound_r ? best_r : cnt_r;
          pl_inc  = 1'b1;
          pl_w1v  = 1'b1;
          pl_w1a  = pfound_r ? best_r : cnt_r;
          pl_w1d  = {addr_r, end_a};
        end
      end
      default: begin
        pl_st = ST_INVALID;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_hs) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_bad) begin
          state_nxt = S_SUM_INIT;
        end else if ((cmd_r != CMD_ALLOC) && (cnt_r == '0)) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (cmd_r == CMD_ALLOC) begin
          state_nxt = q_need ? S_DIV : S_ADV;
        end else if ((cmd_r == CMD_FIXED) && q_in_fix) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        if (cmd_r == CMD_ALLOC) begin
          if (fb_r || (prim_end && found_r)) begin
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else begin
          state_nxt = scan_end ? S_DECIDE : S_SCAN_RD;
        end
      end
      S_DECIDE:   state_nxt = (pl_st == ST_OK) ? S_MV_CHK : S_SUM_INIT;
      S_MV_CHK:   state_nxt = mv_more ? S_MV_WR : S_PUT1;
      S_MV_WR:    state_nxt = S_MV_CHK;
      S_PUT1:     state_nxt = w2v_r ? S_PUT2 : S_SUM_INIT;
      S_PUT2:     state_nxt = S_SUM_INIT;
      S_SUM_INIT: state_nxt = S_SUM_CHK;
      S_SUM_CHK:  state_nxt = (idx_r < cnt_r) ? S_SUM_EV : S_FIN;
      S_SUM_EV:   state_nxt = S_SUM_CHK;
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    tot_nxt    = tot_r;
    cnt_nxt    = cnt_r;
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    al_nxt     = al_r;
    dir_nxt    = dir_r;
    end_nxt    = end_r;
    idx_nxt    = idx_r;
    fb_nxt     = fb_r;
    found_nxt  = found_r;
    best_nxt   = best_r;
    bsz_nxt    = bsz_r;
    bst_nxt    = bst_r;
    ben_nxt    = ben_r;
    ba_nxt     = ba_r;
    cs_nxt     = cs_r;
    ce_nxt     = ce_r;
    x_nxt      = x_r;
    ovl_nxt    = ovl_r;
    pfound_nxt = pfound_r;
    prv_v_nxt  = prv_v_r;
    prv_s_nxt  = prv_s_r;
    prv_e_nxt  = prv_e_r;
    st_nxt     = st_r;
    res_nxt    = res_r;
    w1v_nxt    = w1v_r;
    w1a_nxt    = w1a_r;
    w1d_nxt    = w1d_r;
    w2v_nxt    = w2v_r;
    w2a_nxt    = w2a_r;
    w2d_nxt    = w2d_r;
    mv_on_nxt  = mv_on_r;
    asc_nxt    = asc_r;
    lim_nxt    = lim_r;
    inc_nxt    = inc_r;
    dec_nxt    = dec_r;
    sum_nxt    = sum_r;
    big_nxt    = big_r;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_ra     = idx_r;
    div_start  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wd = {{AB{1'b0}}, tot_r};
      end
      S_IDLE: begin
        if (cfg_hs) begin
          tot_nxt = cfg_ch.total_size;
          cnt_nxt = (cfg_ch.total_size != '0) ? CW'(1) : '0;
          mem_we  = 1'b1;
          mem_wd  = {{AB{1'b0}}, cfg_ch.total_size};
        end else if (in_hs) begin
          cmd_nxt  = cmd_t'(in_ch.command);
          addr_nxt = in_ch.address;
          len_nxt  = in_ch.length;
          al_nxt   = in_ch.alignment;
          dir_nxt  = in_ch.direction;
          res_nxt  = '0;
        end
      end
      S_CHECK: begin
        end_nxt    = end_w;
        st_nxt     = chk_st;
        found_nxt  = 1'b0;
        ovl_nxt    = 1'b0;
        pfound_nxt = 1'b0;
        prv_v_nxt  = 1'b0;
        fb_nxt     = 1'b0;
        idx_nxt    = '0;
        if (cmd_r == CMD_ALLOC) begin
          if (cnt_r == CW'(1)) begin
            fb_nxt = 1'b1;
          end else if (dir_r) begin
            idx_nxt = cnt_r - CW'(1);
          end
        end
      end
      S_SCAN_EV: begin
        cs_nxt = q_s;
        ce_nxt = q_e;
        if (cmd_r == CMD_ALLOC) begin
          if (q_need) begin
            x_nxt     = x_w;
            div_start = 1'b1;
          end
        end else if (cmd_r == CMD_FIXED) begin
          if (q_in_fix) begin
            found_nxt = 1'b1;
            best_nxt  = idx_r;
            bst_nxt   = q_s;
            ben_nxt   = q_e;
          end
        end else begin
          ovl_nxt = ovl_r || q_ovl;
          if (!pfound_r) begin
            if (q_s >= addr_r) begin
              pfound_nxt = 1'b1;
              best_nxt   = idx_r;
              bst_nxt    = q_s;
              ben_nxt    = q_e;
            end else begin
              prv_v_nxt = 1'b1;
              prv_s_nxt = q_s;
              prv_e_nxt = q_e;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done && fit_ok) begin
          found_nxt = 1'b1;
          best_nxt  = idx_r;
          bsz_nxt   = ce_r - cs_r;
          ba_nxt    = a_x[AB-1:0];
          bst_nxt   = cs_r;
          ben_nxt   = ce_r;
        end
      end
      S_ADV: begin
        if (cmd_r == CMD_ALLOC) begin
          if (!fb_r) begin
            if (prim_end) begin
              fb_nxt  = 1'b1;
              idx_nxt = dir_r ? '0 : (cnt_r - CW'(1));
            end else begin
              idx_nxt = dir_r ? (idx_r - CW'(1)) : (idx_r + CW'(1));
            end
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_DECIDE: begin
        st_nxt    = pl_st;
        res_nxt   = pl_res;
        w1v_nxt   = pl_w1v;
        w1a_nxt   = pl_w1a;
        w1d_nxt   = pl_w1d;
        w2v_nxt   = pl_w2v;
        w2a_nxt   = pl_w2a;
        w2d_nxt   = pl_w2d;
        mv_on_nxt = pl_mv;
        asc_nxt   = pl_asc;
        idx_nxt   = pl_from;
        lim_nxt   = pl_lim;
        inc_nxt   = pl_inc;
        dec_nxt   = pl_dec;
      end
      S_MV_CHK: begin
        mem_ra = asc_r ? (idx_r + CW'(1)) : (idx_r - CW'(1));
      end
      S_MV_WR: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r;
        mem_wd  = mem_rq;
        idx_nxt = asc_r ? (idx_r + CW'(1)) : (idx_r - CW'(1));
      end
      S_PUT1: begin
        mem_we  = w1v_r;
        mem_wa  = w1a_r;
        mem_wd  = w1d_r;
        cnt_nxt = cnt_r + CW'(inc_r) - CW'(dec_r);
      end
      S_PUT2: begin
        mem_we = 1'b1;
        mem_wa = w2a_r;
        mem_wd = w2d_r;
      end
      S_SUM_INIT: begin
        idx_nxt = '0;
        sum_nxt = '0;
        big_nxt = '0;
      end
      S_SUM_EV: begin
        sum_nxt = sum_r + q_sz;
        big_nxt = (q_sz > big_r) ? q_sz : big_r;
        idx_nxt = idx_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      tot_r       <= TOT_RST;
      cnt_r       <= (TOT_RST != '0) ? CW'(1) : '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tot_r   <= tot_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    addr_r   <= addr_nxt;
    len_r    <= len_nxt;
    al_r     <= al_nxt;
    dir_r    <= dir_nxt;
    end_r    <= end_nxt;
    idx_r    <= idx_nxt;
    fb_r     <= fb_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    bsz_r    <= bsz_nxt;
    bst_r    <= bst_nxt;
    ben_r    <= ben_nxt;
    ba_r     <= ba_nxt;
    cs_r     <= cs_nxt;
    ce_r     <= ce_nxt;
    x_r      <= x_nxt;
    ovl_r    <= ovl_nxt;
    pfound_r <= pfound_nxt;
    prv_v_r  <= prv_v_nxt;
    prv_s_r  <= prv_s_nxt;
    prv_e_r  <= prv_e_nxt;
    st_r     <= st_nxt;
    res_r    <= res_nxt;
    w1v_r    <= w1v_nxt;
    w1a_r    <= w1a_nxt;
    w1d_r    <= w1d_nxt;
    w2v_r    <= w2v_nxt;
    w2a_r    <= w2a_nxt;
    w2d_r    <= w2d_nxt;
    mv_on_r  <= mv_on_nxt;
    asc_r    <= asc_nxt;
    lim_r    <= lim_nxt;
    inc_r    <= inc_nxt;
    dec_r    <= dec_nxt;
    sum_r    <= sum_nxt;
    big_r    <= big_nxt;
    if (load_out) begin
      o_res_r <= (st_r == ST_OK) ? res_r : '0;
      o_st_r  <= st_r;
      o_tot_r <= sum_r;
      o_big_r <= big_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_address = o_res_r;
  assign out_ch.status         = o_st_r;
  assign out_ch.total_free     = o_tot_r;
  assign out_ch.largest_free   = o_big_r;

  abf_ram #(
    .DEPTH (MAX_RANGES),
    .WIDTH (DW)
  ) u_ram (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa[AW-1:0]),
    .wd  (mem_wd),
    .ra  (mem_ra[AW-1:0]),
    .rq  (mem_rq)
  );

  abf_rem #(
    .W (XW)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (x_w),
    .dvs   (al_r),
    .done  (div_done),
    .rem   (div_rem)
  );
endmodule
`default_nettype wire

FILE: rtl/core/abf_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module abf_rem import abf_pkg::*; #(
  parameter int W = 33
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [W-1:0]       dvd,
  input  wire logic [ALIGN_W-1:0] dvs,
  output logic                    done,
  output logic [ALIGN_W-1:0]      rem
);
  localparam int NW = $clog2(W + 1);

  logic [W-1:0]       dvd_r;
  logic [ALIGN_W-1:0] rem_r;
  logic [ALIGN_W-1:0] rem_nxt;
  logic [NW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [ALIGN_W:0]   sh;
  logic [ALIGN_W:0]   sub;

  always_comb begin
    sh      = {rem_r, dvd_r[W-1]};
    sub     = sh - {1'b0, dvs};
    rem_nxt = (sh >= {1'b0, dvs}) ? sub[ALIGN_W-1:0] : sh[ALIGN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - NW'(1);
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

FILE: rtl/core/abf_ram.sv
// Range table storage: one write port and one registered read port.
`default_nettype none
module abf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]              rq
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rq_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rq_r <= mem[ra];
  end

  assign rq = rq_r;
endmodule
`default_nettype wire
